>>> src/eap_pkg.sv
// Shared types, widths and codes for the eased animation progress block.
`default_nettype none

package eap_pkg;

    // Field widths fixed by the channel and register definitions.
    localparam int CMD_W      = 2;
    localparam int TIME_W     = 32;
    localparam int PROG_W     = 17;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Default number of fraction bits of the progress value.
    localparam int FRAC_BITS_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EASING   = 1'd1;

    // Easing curve codes.
    localparam logic [MODE_W-1:0] MODE_LINEAR       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IN_QUAD      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUT_QUAD     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INOUT_QUAD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IN_CUBIC     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OUT_CUBIC    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INOUT_CUBIC  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_OUT_BOUNCE   = 3'd7;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_MUL1,
        S_MUL2,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

>>> src/eap_if.sv
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none

interface eap_in_if import eap_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [TIME_W-1:0]   current_time;

    modport source (output valid, output cmd, output current_time, input ready);
    modport sink   (input valid, input cmd, input current_time, output ready);
endinterface

interface eap_out_if import eap_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                running;
    logic [PROG_W-1:0]   progress;

    modport source (output valid, output running, output progress, input ready);
    modport sink   (input valid, input running, input progress, output ready);
endinterface

interface eap_cfg_if import eap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/eap_div.sv
// Restoring fractional divider: quotient of num/den scaled by 2^QW, num < den.
`default_nettype none

module eap_div import eap_pkg::*; #(
    parameter int QW = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DUR_W-1:0] i_num,
    input  logic [DUR_W-1:0] i_den,
    output logic             o_done,
    output logic [QW-1:0]    o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] n_rem;
    logic [QW-1:0]    r_quot;
    logic [QW-1:0]    n_quot;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [DUR_W:0]   w_twice;
    logic [DUR_W:0]   w_diff;

    // One quotient bit per cycle: double the remainder, subtract if it fits.
    assign w_twice = {r_rem, 1'b0};
    assign w_diff  = w_twice - {1'b0, i_den};

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_num;
            n_quot = '0;
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_twice >= {1'b0, i_den}) begin
                n_rem  = w_diff[DUR_W-1:0];
                n_quot = {r_quot[QW-2:0], 1'b1};
            end else begin
                n_rem  = w_twice[DUR_W-1:0];
                n_quot = {r_quot[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> src/eap_mul.sv
// Shared fixed-point multiplier with a registered, truncated product (a*b) >> FB.
`default_nettype none

module eap_mul import eap_pkg::*; #(
    parameter int FB = FRAC_BITS_DEF,
    parameter int MW = FB + 3,
    parameter int PW = FB + 4
) (
    input  logic          i_clk,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic [PW-1:0] o_p
);

    logic [2*MW-1:0] w_full;
    logic [PW-1:0]   r_p;

    assign w_full = i_a * i_b;

    // Drop the fraction bits; all curve products stay well below the kept range.
    always_ff @(posedge i_clk) begin
        r_p <= w_full[FB +: PW];
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> src/eased_animation_progress.sv
// Start, stop, idle tick and completing tick give their result in the cycle after accept.
// A tick that evaluates the curve passes through the divider start, FRAC_BITS divider steps,
// a hand-off of the divider done flag, a setup step, up to two multiplier passes and a final
// saturate step before its result is registered.
// One item is in work at a time; the next is taken as the previous result leaves.
// Reset (synchronous, active low) clears the registers, the start time, progress and state.
`default_nettype none

module eased_animation_progress import eap_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eap_in_if.sink     i_in,
    eap_out_if.source  o_out,
    eap_cfg_if.sink    i_cfg
);

    localparam int F  = FRAC_BITS;
    localparam int MW = F + 3;
    localparam int PW = F + 4;
    localparam int EW = F + 1;

    // Curve constants worked out at elaboration.
    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
    localparam longint unsigned D1_L  = ONE_L * 11 / 4;
    localparam longint unsigned N1_L  = ONE_L * 121 / 16;
    localparam longint unsigned B1_L  = ONE_L * ONE_L / D1_L;
    localparam longint unsigned B2_L  = 2 * ONE_L * ONE_L / D1_L;
    localparam longint unsigned B3_L  = (5 * ONE_L / 2) * ONE_L / D1_L;
    localparam longint unsigned C2_L  = (3 * ONE_L / 2) * ONE_L / D1_L;
    localparam longint unsigned C3_L  = (9 * ONE_L / 4) * ONE_L / D1_L;
    localparam longint unsigned C4_L  = (21 * ONE_L / 8) * ONE_L / D1_L;
    localparam longint unsigned O2_L  = 3 * ONE_L / 4;
    localparam longint unsigned O3_L  = 15 * ONE_L / 16;
    localparam longint unsigned O4_L  = 63 * ONE_L / 64;

    localparam logic [F-1:0]  BND1 = F'(B1_L);
    localparam logic [F-1:0]  BND2 = F'(B2_L);
    localparam logic [F-1:0]  BND3 = F'(B3_L);
    localparam logic [F-1:0]  CEN2 = F'(C2_L);
    localparam logic [F-1:0]  CEN3 = F'(C3_L);
    localparam logic [F-1:0]  CEN4 = F'(C4_L);
    localparam logic [F-1:0]  OFS2 = F'(O2_L);
    localparam logic [F-1:0]  OFS3 = F'(O3_L);
    localparam logic [F-1:0]  OFS4 = F'(O4_L);
    localparam logic [MW-1:0] N1_M = MW'(N1_L);
    localparam logic [MW-1:0] ONE_M = MW'(ONE_L);
    localparam logic [PW-1:0] ONE_P = PW'(ONE_L);
    localparam logic [EW-1:0] ONE_E = EW'(ONE_L);

    t_state r_state;
    t_state n_state;

    logic [DUR_W-1:0]  r_dur;
    logic [DUR_W-1:0]  n_dur;
    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] n_start;
    logic              r_active;
    logic              n_active;
    logic [EW-1:0]     r_eased;
    logic [EW-1:0]     n_eased;

    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_out_running;
    logic              n_out_running;
    logic [PROG_W-1:0] r_out_prog;
    logic [PROG_W-1:0] n_out_prog;

    // Operands and finishing flags set up once the normalized time is known.
    logic [MW-1:0]     r_x;
    logic [MW-1:0]     n_x;
    logic [MW-1:0]     r_x2;
    logic [MW-1:0]     n_x2;
    logic [MW-1:0]     r_y;
    logic [MW-1:0]     n_y;
    logic [F-1:0]      r_off;
    logic [F-1:0]      n_off;
    logic              r_neg;
    logic              n_neg;
    logic              r_half;
    logic              n_half;
    logic              r_two;
    logic              n_two;

    logic              w_accept;
    logic              w_cfg_accept;
    logic              w_in_ready;
    logic              w_mul_second;
    logic              w_div_start;
    logic              w_div_done;
    logic [F-1:0]      w_t;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_done_now;
    logic              w_tick_run;
    logic [MW-1:0]     w_t_m;
    logic [MW-1:0]     w_inv;
    logic [MW-1:0]     w_v;
    logic              w_lower;
    logic [F-1:0]      w_cen;
    logic [F-1:0]      w_ofs;
    logic [F-1:0]      w_dist;
    logic [MW-1:0]     w_mul_a;
    logic [MW-1:0]     w_mul_b;
    logic [PW-1:0]     w_mul_p;
    logic [PW-1:0]     w_m;
    logic [PW-1:0]     w_mh;
    logic [PW-1:0]     w_p;
    logic [EW-1:0]     w_sat;

    assign w_accept     = i_in.valid && w_in_ready;
    assign w_cfg_accept = i_cfg.valid;
    assign i_cfg.ready  = 1'b1;
    assign i_in.ready   = w_in_ready;

    // Completion test on the wrapped elapsed time.
    assign w_elapsed  = i_in.current_time - r_start;
    assign w_done_now = (r_dur == '0) ||
                        (({1'b0, w_elapsed} + (TIME_W + 1)'(1)) >= (TIME_W + 1)'(r_dur));
    assign w_tick_run = (i_in.cmd == CMD_TICK) && r_active && !w_done_now;

    eap_div #(.QW(F)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_elapsed[DUR_W-1:0]),
        .i_den   (r_dur),
        .o_done  (w_div_done),
        .o_quot  (w_t)
    );

    // The second pass multiplies the first product by the stored factor.
    assign w_mul_a = w_mul_second ? MW'(w_mul_p) : r_x;
    assign w_mul_b = w_mul_second ? r_y : r_x2;

    eap_mul #(.FB(F), .MW(MW), .PW(PW)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_tick_run) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = (r_mode == MODE_LINEAR) ? S_FIN : S_MUL1;
            end
            S_MUL1: begin
                n_state = r_two ? S_MUL2 : S_FIN;
            end
            S_MUL2:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_in_ready   = 1'b0;
        w_mul_second = 1'b0;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready  = !r_out_valid || o_out.ready;
                w_div_start = i_in.valid && w_in_ready && w_tick_run;
            end
            S_MUL2:  w_mul_second = 1'b1;
            default: ;
        endcase
    end

    // Helpers for the curve setup.
    assign w_t_m   = MW'(w_t);
    assign w_inv   = ONE_M - w_t_m;
    assign w_v     = (ONE_M - w_t_m) << 1;
    assign w_lower = !w_t[F-1];

    // Bounce segment: centre and offset by where t falls.
    always_comb begin
        if (w_t < BND1) begin
            w_cen = '0;
            w_ofs = '0;
        end else if (w_t < BND2) begin
            w_cen = CEN2;
            w_ofs = OFS2;
        end else if (w_t < BND3) begin
            w_cen = CEN3;
            w_ofs = OFS3;
        end else begin
            w_cen = CEN4;
            w_ofs = OFS4;
        end
    end

    assign w_dist = (w_t >= w_cen) ? (w_t - w_cen) : (w_cen - w_t);

    // Final step: optional halving, complement or offset, then saturate to one.
    assign w_m   = (r_mode == MODE_LINEAR) ? PW'(r_x) : w_mul_p;
    assign w_mh  = r_half ? (w_m >> 1) : w_m;
    assign w_p   = r_neg ? (ONE_P - w_mh) : (w_mh + PW'(r_off));
    assign w_sat = (w_p > ONE_P) ? ONE_E : EW'(w_p);

    // Register next values.
    always_comb begin
        n_dur         = r_dur;
        n_mode        = r_mode;
        n_start       = r_start;
        n_active      = r_active;
        n_eased       = r_eased;
        n_out_valid   = r_out_valid;
        n_out_running = r_out_running;
        n_out_prog    = r_out_prog;
        n_x           = r_x;
        n_x2          = r_x2;
        n_y           = r_y;
        n_off         = r_off;
        n_neg         = r_neg;
        n_half        = r_half;
        n_two         = r_two;

        if (w_cfg_accept) begin
            case (i_cfg.index)
                REG_DURATION: n_dur  = i_cfg.data[DUR_W-1:0];
                REG_EASING:   n_mode = i_cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Commands that finish in the accept cycle.
        if (w_accept) begin
            case (i_in.cmd)
                CMD_START: begin
                    n_start  = i_in.current_time;
                    n_eased  = '0;
                    n_active = 1'b1;
                end
                CMD_STOP: n_active = 1'b0;
                CMD_TICK: begin
                    if (r_active && w_done_now) begin
                        n_eased  = ONE_E;
                        n_active = 1'b0;
                    end
                end
                default: ;
            endcase
            if (!w_tick_run) begin
                n_out_valid   = 1'b1;
                n_out_running = n_active;
                n_out_prog    = PROG_W'(n_eased);
            end
        end

        // Curve setup from the normalized time.
        if (r_state == S_PREP) begin
            n_x    = w_t_m;
            n_x2   = w_t_m;
            n_y    = w_t_m;
            n_off  = '0;
            n_neg  = 1'b0;
            n_half = 1'b0;
            n_two  = 1'b0;
            case (r_mode)
                MODE_LINEAR: ;
                MODE_IN_QUAD: ;
                MODE_OUT_QUAD: begin
                    n_x   = w_inv;
                    n_x2  = w_inv;
                    n_neg = 1'b1;
                end
                MODE_INOUT_QUAD: begin
                    if (w_lower) begin
                        n_x = w_t_m << 1;
                    end else begin
                        n_x    = w_v;
                        n_x2   = w_v;
                        n_neg  = 1'b1;
                        n_half = 1'b1;
                    end
                end
                MODE_IN_CUBIC: n_two = 1'b1;
                MODE_OUT_CUBIC: begin
                    n_x   = w_inv;
                    n_x2  = w_inv;
                    n_y   = w_inv;
                    n_neg = 1'b1;
                    n_two = 1'b1;
                end
                MODE_INOUT_CUBIC: begin
                    n_two = 1'b1;
                    if (w_lower) begin
                        n_y = w_t_m << 2;
                    end else begin
                        n_x    = w_v;
                        n_x2   = w_v;
                        n_y    = w_v;
                        n_neg  = 1'b1;
                        n_half = 1'b1;
                    end
                end
                MODE_OUT_BOUNCE: begin
                    n_x   = MW'(w_dist);
                    n_x2  = MW'(w_dist);
                    n_y   = N1_M;
                    n_off = w_ofs;
                    n_two = 1'b1;
                end
                default: ;
            endcase
        end

        // Curve value ready: hold it and present the result.
        if (r_state == S_FIN) begin
            n_eased       = w_sat;
            n_out_valid   = 1'b1;
            n_out_running = r_active;
            n_out_prog    = PROG_W'(w_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dur       <= '0;
            r_mode      <= MODE_LINEAR;
            r_start     <= '0;
            r_active    <= 1'b0;
            r_eased     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dur       <= n_dur;
            r_mode      <= n_mode;
            r_start     <= n_start;
            r_active    <= n_active;
            r_eased     <= n_eased;
            r_out_valid <= n_out_valid;
        end
        r_out_running <= n_out_running;
        r_out_prog    <= n_out_prog;
        r_x           <= n_x;
        r_x2          <= n_x2;
        r_y           <= n_y;
        r_off         <= n_off;
        r_neg         <= n_neg;
        r_half        <= n_half;
        r_two         <= n_two;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.running  = r_out_running;
    assign o_out.progress = r_out_prog;

endmodule

`default_nettype wire

>>> src/eap_checker.sv
// Port-level checks for the eased animation progress block, bound to the top level.
`default_nettype none

module eap_checker import eap_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [CMD_W-1:0]  i_in_cmd,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_out_running,
    input wire logic [PROG_W-1:0] i_out_progress
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_running) && $stable(i_out_progress))
        else $error("result changed while stalled");

    // A start item reports a running channel with zero progress next cycle.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_START) |=>
            i_out_valid && i_out_running && (i_out_progress == '0))
        else $error("start item did not report running with zero progress");

    // A stop item reports a stopped channel next cycle.
    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_STOP) |=>
            i_out_valid && !i_out_running)
        else $error("stop item did not report a stopped channel");

    // The block never takes an item while a result is stuck in the output register.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_ready)
        else $error("item accepted while output register is blocked");

endmodule

bind eased_animation_progress eap_checker u_eap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_running  (o_out.running),
    .i_out_progress (o_out.progress)
);

`default_nettype wire
